[rtl/core/hvps_pkg.sv]
// ----------------------------------------------------------------------------
// hvps_pkg: shared definitions for the precharge sequencer
// Field widths, register indexes, command and fault codes.
// ----------------------------------------------------------------------------
package hvps_pkg;

    localparam int TIME_WIDTH = 32;
    localparam int VOLT_WIDTH = 16;

    localparam int CFG_WIDTH  = 16;
    localparam int FRAC_WIDTH = 9;
    localparam int IDX_WIDTH  = 3;

    // Common width for voltage-to-register compares.
    localparam int VCMP_WIDTH = (VOLT_WIDTH > CFG_WIDTH) ? VOLT_WIDTH : CFG_WIDTH;
    // Width of the fraction times battery product.
    localparam int PROD_WIDTH = VOLT_WIDTH + FRAC_WIDTH;

    // Configuration register indexes.
    localparam logic [IDX_WIDTH-1:0] REG_SETTLE       = 3'd0;
    localparam logic [IDX_WIDTH-1:0] REG_MEAS_TIMEOUT = 3'd1;
    localparam logic [IDX_WIDTH-1:0] REG_BATTERY_MIN  = 3'd2;
    localparam logic [IDX_WIDTH-1:0] REG_BATTERY_MAX  = 3'd3;
    localparam logic [IDX_WIDTH-1:0] REG_PC_MAX       = 3'd4;
    localparam logic [IDX_WIDTH-1:0] REG_PC_FRACTION  = 3'd5;
    localparam logic [IDX_WIDTH-1:0] REG_PC_MIN       = 3'd6;
    localparam logic [IDX_WIDTH-1:0] REG_OVERLAP      = 3'd7;

    // Register reset values.
    localparam logic [CFG_WIDTH-1:0]  RST_SETTLE       = 16'd200;
    localparam logic [CFG_WIDTH-1:0]  RST_MEAS_TIMEOUT = 16'd1000;
    localparam logic [CFG_WIDTH-1:0]  RST_BATTERY_MIN  = 16'd2400;
    localparam logic [CFG_WIDTH-1:0]  RST_BATTERY_MAX  = 16'd6000;
    localparam logic [CFG_WIDTH-1:0]  RST_PC_MAX       = 16'd5000;
    localparam logic [FRAC_WIDTH-1:0] RST_PC_FRACTION  = 9'd243;
    localparam logic [CFG_WIDTH-1:0]  RST_PC_MIN       = 16'd100;
    localparam logic [CFG_WIDTH-1:0]  RST_OVERLAP      = 16'd100;

    // Commands.
    localparam logic [1:0] OP_NONE   = 2'd0;
    localparam logic [1:0] OP_ENABLE = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // Fault codes.
    localparam logic [2:0] FC_CLEAR        = 3'd0;
    localparam logic [2:0] FC_MEAS_TIMEOUT = 3'd1;
    localparam logic [2:0] FC_UNDERVOLT    = 3'd2;
    localparam logic [2:0] FC_OVERVOLT     = 3'd3;
    localparam logic [2:0] FC_PC_TIMEOUT   = 3'd4;
    localparam logic [2:0] FC_TOO_FAST     = 3'd5;
    localparam logic [2:0] FC_LOOP_LOST    = 3'd6;

endpackage

[rtl/core/hv_precharge_sequencer.sv]
// ----------------------------------------------------------------------------
// hv_precharge_sequencer: tractive system precharge sequencer
// Six-state sequencer driving the contactors and the precharge relay.
// The result of an item is registered and valid in the cycle after the item is accepted.
// Throughput: one item per cycle; the state update is a single registered pass.
// Input stalls only while a result is held by a stalled output register.
// Reset: asynchronous, active low; state goes to init, fault code to clear,
// start time to zero, and all configuration registers to their defaults.
// ----------------------------------------------------------------------------
module hv_precharge_sequencer
    import hvps_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_we,
    input  logic [IDX_WIDTH-1:0]  cfg_index,
    input  logic [CFG_WIDTH-1:0]  cfg_data,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  sdc_ok,
    input  logic [1:0]            operation,
    input  logic [TIME_WIDTH-1:0] now_ms,
    input  logic [VOLT_WIDTH-1:0] pack_voltage,
    input  logic [VOLT_WIDTH-1:0] bus_voltage,

    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  air_neg_on,
    output logic                  air_pos_on,
    output logic                  precharge_on,
    output logic [2:0]            seq_state,
    output logic [2:0]            fault_code
);

    typedef enum logic [2:0] {
        ST_INIT      = 3'd0,
        ST_STANDBY   = 3'd1,
        ST_MEASURE   = 3'd2,
        ST_PRECHARGE = 3'd3,
        ST_ENERGIZED = 3'd4,
        ST_FAULT     = 3'd5
    } state_t;

    state_t                  state_reg, state_next;
    logic [TIME_WIDTH-1:0]   start_reg, start_next;
    logic [2:0]              fault_reg, fault_next;

    logic [CFG_WIDTH-1:0]    settle_reg;
    logic [CFG_WIDTH-1:0]    meas_timeout_reg;
    logic [CFG_WIDTH-1:0]    battery_min_reg;
    logic [CFG_WIDTH-1:0]    battery_max_reg;
    logic [CFG_WIDTH-1:0]    pc_max_reg;
    logic [FRAC_WIDTH-1:0]   pc_fraction_reg;
    logic [CFG_WIDTH-1:0]    pc_min_reg;
    logic [CFG_WIDTH-1:0]    overlap_reg;

    logic                    out_valid_reg;
    logic                    neg_reg, pos_reg, pc_reg;
    logic                    neg_next, pos_next, pc_next;

    logic                    accept;
    logic [TIME_WIDTH-1:0]   dt;
    logic [VCMP_WIDTH-1:0]   bat_ext;
    logic [PROD_WIDTH-1:0]   trc_scaled;
    logic [PROD_WIDTH-1:0]   bat_target;
    logic                    target_hit;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    assign dt         = now_ms - start_reg;
    assign bat_ext    = VCMP_WIDTH'(pack_voltage);
    assign trc_scaled = {1'b0, bus_voltage, 8'd0};
    assign bat_target = PROD_WIDTH'(pc_fraction_reg) * PROD_WIDTH'(pack_voltage);
    assign target_hit = trc_scaled >= bat_target;

    always_comb
    begin
        state_next = state_reg;
        start_next = start_reg;
        fault_next = fault_reg;
        neg_next   = 1'b0;
        pos_next   = 1'b0;
        pc_next    = 1'b0;

        if (!sdc_ok)
        begin
            fault_next = FC_LOOP_LOST;
            state_next = ST_STANDBY;
        end
        else
        begin
            case (state_reg)
                ST_INIT:
                begin
                    state_next = ST_STANDBY;
                end
                ST_STANDBY:
                begin
                    if (operation == OP_ENABLE)
                    begin
                        neg_next   = 1'b1;
                        start_next = now_ms;
                        state_next = ST_MEASURE;
                    end
                end
                ST_MEASURE:
                begin
                    // Faults drive all off; waiting and moving on keep the contactor.
                    if (operation != OP_ENABLE)
                    begin
                        state_next = ST_STANDBY;
                    end
                    else if (dt < TIME_WIDTH'(settle_reg))
                    begin
                        neg_next = 1'b1;
                    end
                    else if (dt >= TIME_WIDTH'(meas_timeout_reg))
                    begin
                        fault_next = FC_MEAS_TIMEOUT;
                        state_next = ST_FAULT;
                    end
                    else if (bat_ext < VCMP_WIDTH'(battery_min_reg))
                    begin
                        fault_next = FC_UNDERVOLT;
                        state_next = ST_FAULT;
                    end
                    else if (bat_ext > VCMP_WIDTH'(battery_max_reg))
                    begin
                        fault_next = FC_OVERVOLT;
                        state_next = ST_FAULT;
                    end
                    else
                    begin
                        neg_next   = 1'b1;
                        start_next = now_ms;
                        state_next = ST_PRECHARGE;
                    end
                end
                ST_PRECHARGE:
                begin
                    if (operation != OP_ENABLE)
                    begin
                        state_next = ST_STANDBY;
                    end
                    else if (dt >= TIME_WIDTH'(pc_max_reg))
                    begin
                        fault_next = FC_PC_TIMEOUT;
                        state_next = ST_FAULT;
                    end
                    else if (target_hit && (dt <= TIME_WIDTH'(pc_min_reg)))
                    begin
                        fault_next = FC_TOO_FAST;
                        state_next = ST_FAULT;
                    end
                    else
                    begin
                        neg_next = 1'b1;
                        pc_next  = 1'b1;
                        if (target_hit)
                        begin
                            start_next = now_ms;
                            state_next = ST_ENERGIZED;
                        end
                    end
                end
                ST_ENERGIZED:
                begin
                    if (operation != OP_ENABLE)
                    begin
                        state_next = ST_STANDBY;
                    end
                    else
                    begin
                        neg_next = 1'b1;
                        pos_next = 1'b1;
                        pc_next  = dt < TIME_WIDTH'(overlap_reg);
                    end
                end
                ST_FAULT:
                begin
                    if (operation == OP_CLEAR)
                    begin
                        fault_next = FC_CLEAR;
                        state_next = ST_STANDBY;
                    end
                end
                default:
                begin
                    state_next = ST_FAULT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_INIT;
            start_reg        <= '0;
            fault_reg        <= FC_CLEAR;
            settle_reg       <= RST_SETTLE;
            meas_timeout_reg <= RST_MEAS_TIMEOUT;
            battery_min_reg  <= RST_BATTERY_MIN;
            battery_max_reg  <= RST_BATTERY_MAX;
            pc_max_reg       <= RST_PC_MAX;
            pc_fraction_reg  <= RST_PC_FRACTION;
            pc_min_reg       <= RST_PC_MIN;
            overlap_reg      <= RST_OVERLAP;
            out_valid_reg    <= 1'b0;
            neg_reg          <= 1'b0;
            pos_reg          <= 1'b0;
            pc_reg           <= 1'b0;
            seq_state        <= ST_INIT;
            fault_code       <= FC_CLEAR;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SETTLE:       settle_reg       <= cfg_data;
                    REG_MEAS_TIMEOUT: meas_timeout_reg <= cfg_data;
                    REG_BATTERY_MIN:  battery_min_reg  <= cfg_data;
                    REG_BATTERY_MAX:  battery_max_reg  <= cfg_data;
                    REG_PC_MAX:       pc_max_reg       <= cfg_data;
                    REG_PC_FRACTION:  pc_fraction_reg  <= cfg_data[FRAC_WIDTH-1:0];
                    REG_PC_MIN:       pc_min_reg       <= cfg_data;
                    REG_OVERLAP:      overlap_reg      <= cfg_data;
                    default:          overlap_reg      <= overlap_reg;
                endcase
            end

            if (accept)
            begin
                state_reg     <= state_next;
                start_reg     <= start_next;
                fault_reg     <= fault_next;
                out_valid_reg <= 1'b1;
                neg_reg       <= neg_next;
                pos_reg       <= pos_next;
                pc_reg        <= pc_next;
                seq_state     <= state_next;
                fault_code    <= fault_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign air_neg_on   = neg_reg;
    assign air_pos_on   = pos_reg;
    assign precharge_on = pc_reg;

`ifndef NO_ASSERTIONS
    // Neither the positive contactor nor the precharge relay closes without the negative one.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((!air_pos_on && !precharge_on) || air_neg_on))
        else $error("positive path closed without negative contactor");

    // The fault state always reports everything open.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (seq_state == 3'(ST_FAULT)))
            |-> (!air_neg_on && !air_pos_on && !precharge_on))
        else $error("outputs closed in fault state");

    // A lost safety loop is reported as standby with the loop-lost code.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !sdc_ok) |=>
            (out_valid && (seq_state == 3'(ST_STANDBY)) && (fault_code == FC_LOOP_LOST)))
        else $error("loop lost not handled");

    // The input side only stalls behind a held result.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no result pending");
`endif

endmodule
